FILE: hw/rtl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, constants and helpers of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

   localparam int MAX_DIM     = 8;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int DIM_W       = 4;
   localparam int FIELD_IDX_W = 3;
   localparam int CMD_W       = 2;
   localparam int CSR_IDX_W   = 2;

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   // exact sum of up to MAX_DIM full products
   localparam int ACC_W  = 2 * DATA_W + $clog2(MAX_DIM);

   localparam int CQ_DEPTH = 4;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
   localparam int RQ_DEPTH = 8;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE_A  = 2'd0,
      CMD_WRITE_B  = 2'd1,
      CMD_MULTIPLY = 2'd2
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B    = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [FIELD_IDX_W-1:0]   row;
      logic [FIELD_IDX_W-1:0]   col;
      logic signed [DATA_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [FIELD_IDX_W-1:0]   out_row;
      logic [FIELD_IDX_W-1:0]   out_col;
      logic signed [DATA_W-1:0] product;
      logic                     saturated;
      logic                     last;
   } rsp_item_type;

   typedef struct packed {
      cmd_type                  op;
      logic [ADDR_W-1:0]        addr;
      logic signed [DATA_W-1:0] value;
   } cq_entry_type;

   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] inner;
      logic [DIM_W-1:0] cols;
   } dims_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] res;
      res = d;
      if (d == '0) res = DIM_W'(1);
      else if (32'(d) > MAX_DIM) res = DIM_W'(MAX_DIM);
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
      return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
   endfunction

endpackage

FILE: hw/rtl/mme_front.sv
// ----------------------------------------------------------------------------
// mme_front
// Classifies incoming items and turns them into command queue entries.
// ----------------------------------------------------------------------------
module mme_front
   import mme_pkg::*;
(
   input  logic         push,
   input  logic         full,
   input  req_item_type req_item,
   output logic         cq_push,
   output cq_entry_type cq_entry
);

   logic accept;
   logic in_range;

   assign accept   = push && !full;
   assign in_range = (32'(req_item.row) < MAX_DIM) && (32'(req_item.col) < MAX_DIM);

   always_comb begin
      cq_entry.addr  = mem_addr(IDX_W'(req_item.row), IDX_W'(req_item.col));
      cq_entry.value = req_item.value;
      cq_entry.op    = CMD_MULTIPLY;
      cq_push        = 1'b0;
      case (req_item.command)
         CMD_WRITE_A: begin
            cq_entry.op = CMD_WRITE_A;
            cq_push     = accept && in_range;
         end
         CMD_WRITE_B: begin
            cq_entry.op = CMD_WRITE_B;
            cq_push     = accept && in_range;
         end
         CMD_MULTIPLY: begin
            cq_entry.op = CMD_MULTIPLY;
            cq_push     = accept;
         end
         default: begin
            // unused command code, dropped
            cq_push = 1'b0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/mme_cmd_queue.sv
// ----------------------------------------------------------------------------
// mme_cmd_queue
// Short queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module mme_cmd_queue
   import mme_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  cq_entry_type wr_data,
   output logic         full,
   input  logic         rd_en,
   output cq_entry_type rd_data,
   output logic         empty
);

   cq_entry_type          entries_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]   count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full    = (count_ff == CQ_CNT_W'(CQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + CQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + CQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CQ_CNT_W'(do_wr) - CQ_CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) entries_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

FILE: hw/rtl/mme_rsp_queue.sv
// ----------------------------------------------------------------------------
// mme_rsp_queue
// Result queue that holds finished product elements until they are taken.
// ----------------------------------------------------------------------------
module mme_rsp_queue
   import mme_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  rsp_item_type        wr_data,
   output logic [RQ_CNT_W-1:0] count,
   input  logic                rd_en,
   output rsp_item_type        rd_data,
   output logic                empty
);

   rsp_item_type          entries_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0]   count_ff, count_in;
   logic                  do_rd;

   // the back end never pushes without a reserved slot
   assign count   = count_ff;
   assign empty   = (count_ff == '0);
   assign do_rd   = rd_en && !empty;
   assign rd_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + RQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + RQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RQ_CNT_W'(wr_en) - RQ_CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) entries_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

FILE: hw/rtl/mme_back.sv
// ----------------------------------------------------------------------------
// mme_back
// Operand stores, multiply sequencer and pipelined multiply-accumulate.
// ----------------------------------------------------------------------------
module mme_back
   import mme_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dims_type            dims,
   input  logic                cq_empty,
   input  cq_entry_type        cq_entry,
   output logic                cq_pop,
   input  logic [RQ_CNT_W-1:0] rq_count,
   output logic                rq_push,
   output rsp_item_type        rq_entry
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } seq_state_type;

   typedef struct packed {
      logic             first;
      logic             last_k;
      logic             elem_last;
      logic [IDX_W-1:0] r;
      logic [IDX_W-1:0] c;
   } tag_type;

   logic signed [DATA_W-1:0] store_a [DEPTH];
   logic signed [DATA_W-1:0] store_b [DEPTH];

   seq_state_type            state_ff, state_in;
   logic [IDX_W-1:0]         r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [RQ_CNT_W-1:0]      pend_ff, pend_in;
   logic [IDX_W-1:0]         nr_m1, nk_m1, nc_m1;
   logic                     room, issue, wr_a, wr_b;
   logic [ADDR_W-1:0]        a_addr, b_addr;
   tag_type                  tag;

   logic signed [DATA_W-1:0]   a_rd_ff, b_rd_ff;
   logic                       s1_valid_ff, s1_valid_in;
   tag_type                    s1_tag_ff;
   logic                       s2_valid_ff, s2_valid_in;
   tag_type                    s2_tag_ff;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       s3_valid_ff, s3_valid_in;
   tag_type                    s3_tag_ff;
   logic signed [ACC_W-1:0]    sum_ff;
   logic signed [ACC_W-1:0]    shifted;
   logic                       fits;

   assign nr_m1 = IDX_W'(clamp_dim(dims.rows)  - DIM_W'(1));
   assign nk_m1 = IDX_W'(clamp_dim(dims.inner) - DIM_W'(1));
   assign nc_m1 = IDX_W'(clamp_dim(dims.cols)  - DIM_W'(1));

   // a new element starts only with a result slot reserved for it
   assign room  = ((RQ_CNT_W+1)'(rq_count) + (RQ_CNT_W+1)'(pend_ff))
                  < (RQ_CNT_W+1)'(RQ_DEPTH);
   assign issue = (state_ff == ST_RUN) && ((k_ff != '0) || room);

   assign cq_pop = (state_ff == ST_IDLE) && !cq_empty;
   assign wr_a   = cq_pop && (cq_entry.op == CMD_WRITE_A);
   assign wr_b   = cq_pop && (cq_entry.op == CMD_WRITE_B);

   assign a_addr = mem_addr(r_ff, k_ff);
   assign b_addr = mem_addr(k_ff, c_ff);

   always_comb begin
      tag.first     = (k_ff == '0);
      tag.last_k    = (k_ff == nk_m1);
      tag.elem_last = (r_ff == nr_m1) && (c_ff == nc_m1);
      tag.r         = r_ff;
      tag.c         = c_ff;
   end

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cq_pop && (cq_entry.op == CMD_MULTIPLY)) begin
               state_in = ST_RUN;
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (k_ff == nk_m1) begin
                  k_in = '0;
                  if (c_ff == nc_m1) begin
                     c_in = '0;
                     if (r_ff == nr_m1) begin
                        r_in     = '0;
                        state_in = ST_IDLE;
                     end else begin
                        r_in = r_ff + IDX_W'(1);
                     end
                  end else begin
                     c_in = c_ff + IDX_W'(1);
                  end
               end else begin
                  k_in = k_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pend_in     = pend_ff + RQ_CNT_W'(issue && tag.first) - RQ_CNT_W'(rq_push);
      s1_valid_in = issue;
      s2_valid_in = s1_valid_ff;
      s3_valid_in = s2_valid_ff && s2_tag_ff.last_k;
      prod_in     = a_rd_ff * b_rd_ff;
      acc_in      = s2_tag_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         r_ff        <= '0;
         c_ff        <= '0;
         k_ff        <= '0;
         pend_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         r_ff        <= r_in;
         c_ff        <= c_in;
         k_ff        <= k_in;
         pend_ff     <= pend_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // operand stores, registered reads
   always_ff @(posedge clock) begin
      if (wr_a)  store_a[cq_entry.addr] <= cq_entry.value;
      if (issue) a_rd_ff <= store_a[a_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_b)  store_b[cq_entry.addr] <= cq_entry.value;
      if (issue) b_rd_ff <= store_b[b_addr];
   end

   always_ff @(posedge clock) begin
      if (issue)       s1_tag_ff <= tag;
      if (s1_valid_ff) begin
         s2_tag_ff <= s1_tag_ff;
         prod_ff   <= prod_in;
      end
      if (s2_valid_ff) acc_ff <= acc_in;
      if (s3_valid_in) begin
         s3_tag_ff <= s2_tag_ff;
         sum_ff    <= acc_in;
      end
   end

   // scale and saturate
   assign shifted = sum_ff >>> FRAC_BITS;
   assign fits    = (shifted[ACC_W-1:DATA_W-1] == '0) || (shifted[ACC_W-1:DATA_W-1] == '1);

   always_comb begin
      rq_push            = s3_valid_ff;
      rq_entry.out_row   = FIELD_IDX_W'(s3_tag_ff.r);
      rq_entry.out_col   = FIELD_IDX_W'(s3_tag_ff.c);
      rq_entry.saturated = !fits;
      rq_entry.last      = s3_tag_ff.elem_last;
      if (fits)
         rq_entry.product = shifted[DATA_W-1:0];
      else if (sum_ff[ACC_W-1])
         rq_entry.product = {1'b1, {(DATA_W-1){1'b0}}};
      else
         rq_entry.product = {1'b0, {(DATA_W-1){1'b1}}};
   end

endmodule

FILE: hw/rtl/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Fixed-point matrix multiply with element-write loading and a result queue.
// ----------------------------------------------------------------------------
// Element writes to A or B are taken one per cycle while full is low and
// land in the operand stores in order. A multiply command produces
// rows_a x cols_b result transfers in row-major order, the final one
// marked with last; it occupies the single shared multiply-accumulate
// unit for rows_a x cols_b x inner_dim product terms, one term per cycle,
// and stalls before an element when no unreserved result slot remains.
// A four-entry command queue sits between the input side and the compute
// side, so full rises only once that queue fills behind a running multiply.
// Elements are signed Q16.16; sums are exact, shifted right arithmetically
// (rounding toward minus infinity) and saturated to 32 bits with a flag.
// Dimension registers take 0 as 1 and clamp above the store size; reading
// a store entry never written gives an undefined element.
// ----------------------------------------------------------------------------
module matrix_multiply_engine
   import mme_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // input item queue
   input  logic                 push,
   output logic                 full,
   input  req_item_type         req_item,
   // result queue
   output logic                 empty,
   input  logic                 pop,
   output rsp_item_type         rsp_item,
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   logic [DIM_W-1:0]    rows_ff, rows_in;
   logic [DIM_W-1:0]    inner_ff, inner_in;
   logic [DIM_W-1:0]    cols_ff, cols_in;
   dims_type            dims;

   logic                cq_push, cq_pop, cq_empty;
   cq_entry_type        cq_wr_entry, cq_rd_entry;
   logic                rq_push;
   rsp_item_type        rq_entry;
   logic [RQ_CNT_W-1:0] rq_count;

   // dimension registers, writes to unknown indexes are dropped
   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ROWS_A:    rows_in  = csr_wdata;
            REG_INNER_DIM: inner_in = csr_wdata;
            REG_COLS_B:    cols_in  = csr_wdata;
            default:       rows_in  = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= DIM_W'(8);
         inner_ff <= DIM_W'(8);
         cols_ff  <= DIM_W'(8);
      end else begin
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
      end
   end

   assign dims.rows  = rows_ff;
   assign dims.inner = inner_ff;
   assign dims.cols  = cols_ff;

   // front: classify transfers, drop unused codes and out-of-range writes
   mme_front u_front (
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .cq_push  (cq_push),
      .cq_entry (cq_wr_entry)
   );

   mme_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cq_push),
      .wr_data (cq_wr_entry),
      .full    (full),
      .rd_en   (cq_pop),
      .rd_data (cq_rd_entry),
      .empty   (cq_empty)
   );

   // back: stores, sequencer and multiply-accumulate pipeline
   mme_back u_back (
      .clock    (clock),
      .reset    (reset),
      .dims     (dims),
      .cq_empty (cq_empty),
      .cq_entry (cq_rd_entry),
      .cq_pop   (cq_pop),
      .rq_count (rq_count),
      .rq_push  (rq_push),
      .rq_entry (rq_entry)
   );

   mme_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rq_push),
      .wr_data (rq_entry),
      .count   (rq_count),
      .rd_en   (pop),
      .rd_data (rsp_item),
      .empty   (empty)
   );

endmodule
